// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared sizes, status codes, command word and engine states.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Pool geometry and header overhead.
	localparam int POOL_LOG2      = 16;
	localparam int MIN_BLOCK_LOG2 = 6;
	localparam int HEADER_BYTES   = 32;
	localparam int LEVELS         = POOL_LOG2 - MIN_BLOCK_LOG2;
	localparam int NODE_COUNT     = (2 << LEVELS) - 1;
	localparam int NODE_W         = $clog2(NODE_COUNT);
	localparam int DEPTH_W        = $clog2(LEVELS + 1);
	localparam int ADDR_W         = 16;
	localparam int USED_W         = 17;

	// State of one tree node.
	typedef enum logic [1:0] {
		NS_UNUSED = 2'd0,
		NS_FREE   = 2'd1,
		NS_ALLOC  = 2'd2,
		NS_SPLIT  = 2'd3
	} node_st_t;

	// Result status codes.
	typedef enum logic [1:0] {
		RS_OK       = 2'd0,
		RS_INVALID  = 2'd1,
		RS_NO_SPACE = 2'd2,
		RS_BAD_ADDR = 2'd3
	} res_st_t;

	// Request modes.
	typedef enum logic [1:0] {
		MD_ALLOC = 2'd0,
		MD_FREE  = 2'd1,
		MD_RESET = 2'd2,
		MD_SPARE = 2'd3
	} mode_t;

	// Classified command kinds.
	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_REJECT = 2'd3
	} cmd_kind_t;

	// Command word passed from the front end to the engine.
	typedef struct packed {
		cmd_kind_t           kind;
		res_st_t             rej;
		logic [DEPTH_W-1:0]  depth;
		logic [ADDR_W-1:0]   start;
	} cmd_t;

	// Engine states.
	typedef enum logic [3:0] {
		ES_CLR,
		ES_IDLE,
		ES_SCAN,
		ES_SP_A,
		ES_SP_B,
		ES_FW_RD,
		ES_FW_CK,
		ES_FR_W,
		ES_MG_RD,
		ES_MG_CK,
		ES_MG_W2,
		ES_MG_W3
	} eng_st_t;

endpackage

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2047
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bba_queue.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator command queue
// Two-entry queue between the front end and the engine.
// ----------------------------------------------------------------------------
module bba_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bba_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output bba_pkg::cmd_t dout,
	output logic          empty
);
	import bba_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/bba_front.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator front end
// Accepts request words and classifies them into engine commands.
// ----------------------------------------------------------------------------
module bba_front (
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // request_bytes[15:0], free_address[31:16]
	input  logic [1:0]    s_tuser,   // mode[1:0]
	input  logic          full,
	output logic          push,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	logic [ADDR_W-1:0]  req;
	logic [ADDR_W-1:0]  faddr;
	logic [USED_W-1:0]  need;
	logic               fit;
	logic [DEPTH_W-1:0] dpt;

	assign req      = s_tdata[15:0];
	assign faddr    = s_tdata[31:16];
	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	// Smallest order whose block holds the request plus header.
	always_comb begin
		need = {1'b0, req} + USED_W'(HEADER_BYTES);
		fit  = 1'b0;
		dpt  = '0;
		for (int o = POOL_LOG2; o >= MIN_BLOCK_LOG2; o--) begin
			if ((USED_W'(1) << o) >= need) begin
				fit = 1'b1;
				dpt = DEPTH_W'(POOL_LOG2 - o);
			end
		end
	end

	// Command classification.
	always_comb begin
		cmd.kind  = CMD_REJECT;
		cmd.rej   = RS_INVALID;
		cmd.depth = dpt;
		cmd.start = faddr - ADDR_W'(HEADER_BYTES);
		case (mode_t'(s_tuser))
			MD_ALLOC: begin
				if (req == '0) begin
					cmd.rej = RS_INVALID;
				end else if (!fit) begin
					cmd.rej = RS_NO_SPACE;
				end else begin
					cmd.kind = CMD_ALLOC;
				end
			end
			MD_FREE: begin
				if (faddr < ADDR_W'(HEADER_BYTES)) begin
					cmd.rej = RS_BAD_ADDR;
				end else begin
					cmd.kind = CMD_FREE;
				end
			end
			MD_RESET: begin
				cmd.kind = CMD_CLEAR;
			end
			default: begin
				cmd.rej = RS_INVALID;
			end
		endcase
	end

endmodule

// ===== hdl/bba_engine.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator engine
// Walks the block tree to allocate, free, merge and clear; holds the result.
// ----------------------------------------------------------------------------
module bba_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  bba_pkg::cmd_t cmd,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [39:0]   m_tdata,   // granted_address[15:0], used_bytes[32:16]
	output logic [1:0]    m_tuser    // status[1:0]
);
	import bba_pkg::*;

	eng_st_t             state_q, state_d;
	logic [NODE_W-1:0]   node_q, idx_q, chk_idx_q, clr_cnt_q;
	logic [DEPTH_W-1:0]  d_q, dt_q, chk_d_q;
	logic                iss_q, chk_v_q, clr_emit_q;
	logic [ADDR_W-1:0]   start_q, base_q;
	logic [USED_W-1:0]   used_q, used_d;
	logic                out_v_q;
	res_st_t             out_st_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [USED_W-1:0]   out_used_q;

	logic                we;
	logic [NODE_W-1:0]   waddr, raddr;
	node_st_t            wdata;
	logic [1:0]          rdata;
	logic                emit;
	res_st_t             emit_st;
	logic [ADDR_W-1:0]   emit_addr;
	logic [NODE_W-1:0]   sib, parent, lchild, rchild;
	logic                found;
	logic [USED_W-1:0]   blk_size;

	// First and last node index of a tree level.
	function automatic logic [NODE_W-1:0] level_first(input logic [DEPTH_W-1:0] d);
		level_first = NODE_W'((32'd1 << d) - 32'd1);
	endfunction

	function automatic logic [NODE_W-1:0] level_last(input logic [DEPTH_W-1:0] d);
		level_last = NODE_W'((32'd2 << d) - 32'd2);
	endfunction

	bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Tree neighbors of the current node and its block size.
	assign sib      = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
	assign parent   = (node_q - NODE_W'(1)) >> 1;
	assign lchild   = NODE_W'({node_q, 1'b1});
	assign rchild   = NODE_W'({node_q, 1'b0} + (NODE_W + 1)'(2));
	assign blk_size = USED_W'(1) << (POOL_LOG2 - int'(d_q));
	assign found    = chk_v_q && (rdata == NS_FREE);

	// Next state, memory controls and result strobe.
	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = node_q;
		wdata     = NS_UNUSED;
		raddr     = node_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_st   = RS_OK;
		emit_addr = '0;
		used_d    = used_q;
		case (state_q)
			ES_CLR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = (clr_cnt_q == '0) ? NS_FREE : NS_UNUSED;
				if (clr_cnt_q == NODE_W'(NODE_COUNT - 1)) begin
					state_d = ES_IDLE;
					emit    = clr_emit_q;
					used_d  = '0;
				end
			end
			ES_IDLE: begin
				if (!cmd_empty && !out_v_q) begin
					pop = 1'b1;
					case (cmd.kind)
						CMD_ALLOC: state_d = ES_SCAN;
						CMD_FREE:  state_d = ES_FW_RD;
						CMD_CLEAR: state_d = ES_CLR;
						default: begin
							emit    = 1'b1;
							emit_st = cmd.rej;
						end
					endcase
				end
			end
			ES_SCAN: begin
				raddr = idx_q;
				if (found) begin
					state_d = ES_SP_A;
				end else if (!iss_q && !chk_v_q) begin
					emit    = 1'b1;
					emit_st = RS_NO_SPACE;
					state_d = ES_IDLE;
				end
			end
			ES_SP_A: begin
				we = 1'b1;
				if (d_q == dt_q) begin
					wdata     = NS_ALLOC;
					used_d    = used_q + blk_size;
					emit      = 1'b1;
					emit_addr = base_q + ADDR_W'(HEADER_BYTES);
					state_d   = ES_IDLE;
				end else begin
					wdata   = NS_SPLIT;
					state_d = ES_SP_B;
				end
			end
			ES_SP_B: begin
				we      = 1'b1;
				waddr   = rchild;
				wdata   = NS_FREE;
				state_d = ES_SP_A;
			end
			ES_FW_RD: begin
				state_d = ES_FW_CK;
			end
			ES_FW_CK: begin
				if (rdata == NS_ALLOC) begin
					if (base_q == start_q) begin
						state_d = ES_FR_W;
					end else begin
						emit    = 1'b1;
						emit_st = RS_BAD_ADDR;
						state_d = ES_IDLE;
					end
				end else if (rdata != NS_SPLIT || d_q >= DEPTH_W'(LEVELS)) begin
					emit    = 1'b1;
					emit_st = RS_BAD_ADDR;
					state_d = ES_IDLE;
				end else begin
					state_d = ES_FW_RD;
				end
			end
			ES_FR_W: begin
				we      = 1'b1;
				wdata   = NS_FREE;
				used_d  = (used_q >= blk_size) ? used_q - blk_size : '0;
				state_d = ES_MG_RD;
			end
			ES_MG_RD: begin
				raddr = sib;
				if (node_q == '0) begin
					used_d  = '0;
					emit    = 1'b1;
					state_d = ES_IDLE;
				end else begin
					state_d = ES_MG_CK;
				end
			end
			ES_MG_CK: begin
				if (rdata != NS_FREE) begin
					emit    = 1'b1;
					state_d = ES_IDLE;
				end else begin
					we      = 1'b1;
					state_d = ES_MG_W2;
				end
			end
			ES_MG_W2: begin
				we      = 1'b1;
				waddr   = sib;
				state_d = ES_MG_W3;
			end
			ES_MG_W3: begin
				we      = 1'b1;
				waddr   = parent;
				wdata   = NS_FREE;
				state_d = ES_MG_RD;
			end
			default: begin
				state_d = ES_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ES_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: clearing pass, scan issue, used count, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_emit_q <= 1'b0;
			iss_q      <= 1'b0;
			chk_v_q    <= 1'b0;
			used_q     <= '0;
			out_v_q    <= 1'b0;
		end else begin
			used_q <= used_d;
			if (state_q == ES_CLR) begin
				clr_cnt_q <= clr_cnt_q + NODE_W'(1);
			end
			if (pop && cmd.kind == CMD_CLEAR) begin
				clr_cnt_q  <= '0;
				clr_emit_q <= 1'b1;
			end
			if (pop && cmd.kind == CMD_ALLOC) begin
				iss_q   <= 1'b1;
				chk_v_q <= 1'b0;
			end else if (state_q == ES_SCAN) begin
				chk_v_q <= iss_q;
				if (iss_q && idx_q == level_last(d_q) && d_q == '0) begin
					iss_q <= 1'b0;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Walk datapath: node index, depth, block base and result payload.
	always_ff @(posedge clk) begin
		if (pop && cmd.kind == CMD_ALLOC) begin
			dt_q  <= cmd.depth;
			d_q   <= cmd.depth;
			idx_q <= level_first(cmd.depth);
		end
		if (pop && cmd.kind == CMD_FREE) begin
			node_q  <= '0;
			d_q     <= '0;
			base_q  <= '0;
			start_q <= cmd.start;
		end
		case (state_q)
			ES_SCAN: begin
				chk_idx_q <= idx_q;
				chk_d_q   <= d_q;
				if (found) begin
					node_q <= chk_idx_q;
					d_q    <= chk_d_q;
					base_q <= ADDR_W'(32'(chk_idx_q - level_first(chk_d_q))
						<< (POOL_LOG2 - int'(chk_d_q)));
				end else if (iss_q) begin
					if (idx_q == level_last(d_q)) begin
						if (d_q != '0) begin
							d_q   <= d_q - DEPTH_W'(1);
							idx_q <= level_first(d_q - DEPTH_W'(1));
						end
					end else begin
						idx_q <= idx_q + NODE_W'(1);
					end
				end
			end
			ES_SP_B: begin
				node_q <= lchild;
				d_q    <= d_q + DEPTH_W'(1);
			end
			ES_FW_CK: begin
				// Descend only through a split node; an allocated node stays put.
				if (rdata == NS_SPLIT && d_q < DEPTH_W'(LEVELS)) begin
					if (start_q[ADDR_W - 1 - int'(d_q)]) begin
						node_q <= rchild;
						base_q <= base_q | (ADDR_W'(1) << (ADDR_W - 1 - int'(d_q)));
					end else begin
						node_q <= lchild;
					end
					d_q <= d_q + DEPTH_W'(1);
				end
			end
			ES_MG_W3: begin
				node_q <= parent;
				d_q    <= d_q - DEPTH_W'(1);
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_st_q   <= emit_st;
			out_addr_q <= emit_addr;
			out_used_q <= used_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {7'b0, out_used_q, out_addr_q};

	// The used-byte count never exceeds the pool.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (USED_W'(1) << POOL_LOG2))
		else $error("used byte count exceeds pool size");

	// Commands are taken only by an idle engine with an empty result slot.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ES_IDLE && !out_v_q))
		else $error("command popped while busy");

	// A result never overwrites one still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_v_q)
		else $error("result overwritten");

	// Splitting never goes below the requested depth.
	a_split_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ES_SP_A) |-> (d_q <= dt_q))
		else $error("split passed target depth");

endmodule

// ===== hdl/buddy_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates, frees and merges power-of-two blocks of a 64 KiB pool.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: request_bytes, free_address
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: granted_address, used_bytes
//
// One request word gives one result word. Allocate scans the node store one node
// per cycle from the requested level upward (at most 2047 reads), then splits the
// found block down to the requested depth. Free walks split nodes down to the
// allocated block, frees it and merges free buddies. A clearing pass writes every
// node after reset and on a reset-mode word. A two-word queue keeps accepting while
// the engine works or a result waits; a stalled output holds the engine.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_bytes[15:0], free_address[31:16]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // granted_address[15:0], used_bytes[32:16]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import bba_pkg::*;

	logic push, full, pop, empty;
	cmd_t cmd_in, cmd_out;

	bba_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.cmd      (cmd_in)
	);

	bba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (pop),
		.dout   (cmd_out),
		.empty  (empty)
	);

	bba_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (empty),
		.cmd       (cmd_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
